// ===== design/hsvd_pkg.sv =====
// Shared types and constants for the HSV to RGBW duty converter.
// No dependencies; every other design file refers to this package by scoped names.
package hsvd_pkg;

	// Field widths
	localparam int unsigned CompW = 12;
	localparam int unsigned DutyW = 14;
	localparam int unsigned PctW  = 7;
	localparam int unsigned FracW = 10;
	localparam int unsigned IdxW  = 3;

	// Hue folding and sector constants
	localparam logic [CompW-1:0] HueFold    = 12'd3960;
	localparam logic [CompW-1:0] SectorSize = 12'd660;
	localparam logic [FracW-1:0] SectorDiv  = 10'd659;
	localparam logic [CompW-1:0] FullScale  = 12'd4095;
	localparam logic [21:0]      TermTop    = 22'd2698605;

	// Reciprocal of 659 scaled by 2^31 (rounded up), exact for numerators up to TermTop.
	localparam logic [21:0] Recip659  = 22'd3258701;
	localparam int unsigned Recip659Sh = 31;

	// Reciprocal of 100 scaled by 2^27 (rounded up), exact for products up to 16380 * 100.
	localparam logic [20:0] Recip100  = 21'd1342178;
	localparam int unsigned Recip100Sh = 27;

	localparam logic [PctW-1:0] DutyMax = 7'd100;

	// Configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_WIDE       = 3'd0,
		REG_DUTY_RED   = 3'd1,
		REG_DUTY_GREEN = 3'd2,
		REG_DUTY_BLUE  = 3'd3,
		REG_DUTY_WHITE = 3'd4
	} hsvd_reg_t;

	// Sixty-degree hue sectors
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} hsvd_sector_t;

	// Input transaction
	typedef struct packed {
		logic [CompW-1:0] hue;
		logic [CompW-1:0] saturation;
		logic [CompW-1:0] brightness;
	} hsvd_in_t;

	// Result transaction
	typedef struct packed {
		logic [DutyW-1:0] red_duty;
		logic [DutyW-1:0] green_duty;
		logic [DutyW-1:0] blue_duty;
		logic [DutyW-1:0] white_duty;
	} hsvd_out_t;

	// Position of a color inside its hue sector, handed from the sector stage on
	typedef struct packed {
		hsvd_sector_t     sector;
		logic [FracW-1:0] frac;
		logic [CompW-1:0] sat;
		logic [CompW-1:0] val;
	} hsvd_pos_t;

	// Unscaled channel levels
	typedef struct packed {
		logic [CompW-1:0] red;
		logic [CompW-1:0] green;
		logic [CompW-1:0] blue;
		logic [CompW-1:0] white;
	} hsvd_chan_t;

endpackage

// ===== design/hsvd_sector.sv =====
// Stage 1 of the converter: folds the hue and splits it into sector and fraction.
// Depends on hsvd_pkg.
module hsvd_sector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  hsvd_pkg::hsvd_in_t  pixel,
	output logic                valid_s1,
	output hsvd_pkg::hsvd_pos_t pos_s1
);

	logic [hsvd_pkg::CompW-1:0] hue_fold;
	logic [hsvd_pkg::CompW-1:0] base;
	logic [hsvd_pkg::CompW-1:0] frac_full;
	hsvd_pkg::hsvd_sector_t     sector;

	// Fold the hue into one turn, then find the sector by comparing against its edges.
	always_comb begin
		if (pixel.hue >= hsvd_pkg::HueFold) begin
			hue_fold = pixel.hue - hsvd_pkg::HueFold;
		end else begin
			hue_fold = pixel.hue;
		end
		if (hue_fold >= 12'(5 * hsvd_pkg::SectorSize)) begin
			sector = hsvd_pkg::SEC_M_TO_R;
			base   = 12'(5 * hsvd_pkg::SectorSize);
		end else if (hue_fold >= 12'(4 * hsvd_pkg::SectorSize)) begin
			sector = hsvd_pkg::SEC_B_TO_M;
			base   = 12'(4 * hsvd_pkg::SectorSize);
		end else if (hue_fold >= 12'(3 * hsvd_pkg::SectorSize)) begin
			sector = hsvd_pkg::SEC_C_TO_B;
			base   = 12'(3 * hsvd_pkg::SectorSize);
		end else if (hue_fold >= 12'(2 * hsvd_pkg::SectorSize)) begin
			sector = hsvd_pkg::SEC_G_TO_C;
			base   = 12'(2 * hsvd_pkg::SectorSize);
		end else if (hue_fold >= hsvd_pkg::SectorSize) begin
			sector = hsvd_pkg::SEC_Y_TO_G;
			base   = hsvd_pkg::SectorSize;
		end else begin
			sector = hsvd_pkg::SEC_R_TO_Y;
			base   = '0;
		end
		frac_full = hue_fold - base;
	end

	// Valid bit of the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// Payload of the first stage.
	always_ff @(posedge clk) begin
		pos_s1.sector <= sector;
		pos_s1.frac   <= frac_full[hsvd_pkg::FracW-1:0];
		pos_s1.sat    <= pixel.saturation;
		pos_s1.val    <= pixel.brightness;
	end

endmodule

// ===== design/hsvd_terms.sv =====
// Stages 2 to 6 of the converter: forms the p, q and t terms and maps them to channels.
// Depends on hsvd_pkg; fed by hsvd_sector.
module hsvd_terms (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  hsvd_pkg::hsvd_pos_t  pos_s1,
	output logic                 valid_s6,
	output hsvd_pkg::hsvd_chan_t chan_s6
);

	// Stage 2: products
	logic                       valid_s2;
	logic [21:0]                sf_s2;
	logic [21:0]                sg_s2;
	logic [23:0]                pv_s2;
	logic [hsvd_pkg::CompW-1:0] val_s2;
	hsvd_pkg::hsvd_sector_t     sector_s2;

	// Stage 3: dividends
	logic                       valid_s3;
	logic [21:0]                nq_s3;
	logic [21:0]                nt_s3;
	logic [hsvd_pkg::CompW-1:0] p_s3;
	logic [hsvd_pkg::CompW-1:0] val_s3;
	hsvd_pkg::hsvd_sector_t     sector_s3;

	// Stage 4: quotients by 659
	logic                       valid_s4;
	logic [hsvd_pkg::CompW-1:0] dq_s4;
	logic [hsvd_pkg::CompW-1:0] dt_s4;
	logic [hsvd_pkg::CompW-1:0] p_s4;
	logic [hsvd_pkg::CompW-1:0] val_s4;
	hsvd_pkg::hsvd_sector_t     sector_s4;

	// Stage 5: terms scaled by value
	logic                       valid_s5;
	logic [hsvd_pkg::CompW-1:0] q_s5;
	logic [hsvd_pkg::CompW-1:0] t_s5;
	logic [hsvd_pkg::CompW-1:0] p_s5;
	logic [hsvd_pkg::CompW-1:0] val_s5;
	hsvd_pkg::hsvd_sector_t     sector_s5;

	logic [hsvd_pkg::CompW-1:0] val_s6;

	logic [hsvd_pkg::FracW-1:0] frac_c;
	logic [43:0]                prod_q;
	logic [43:0]                prod_t;
	logic [23:0]                vq;
	logic [23:0]                vt;
	hsvd_pkg::hsvd_chan_t       chan_mux;

	assign frac_c = hsvd_pkg::SectorDiv - pos_s1.frac;
	assign prod_q = 44'(nq_s3) * 44'(hsvd_pkg::Recip659);
	assign prod_t = 44'(nt_s3) * 44'(hsvd_pkg::Recip659);
	assign vq     = 24'(val_s4) * 24'(dq_s4);
	assign vt     = 24'(val_s4) * 24'(dt_s4);

	// Sector mapping of the value, p, q and t terms onto red, green and blue.
	always_comb begin
		chan_mux.red   = val_s5;
		chan_mux.green = val_s5;
		chan_mux.blue  = val_s5;
		chan_mux.white = p_s5;
		case (sector_s5)
			hsvd_pkg::SEC_R_TO_Y: begin
				chan_mux.green = t_s5;
				chan_mux.blue  = p_s5;
			end
			hsvd_pkg::SEC_Y_TO_G: begin
				chan_mux.red  = q_s5;
				chan_mux.blue = p_s5;
			end
			hsvd_pkg::SEC_G_TO_C: begin
				chan_mux.red  = p_s5;
				chan_mux.blue = t_s5;
			end
			hsvd_pkg::SEC_C_TO_B: begin
				chan_mux.red   = p_s5;
				chan_mux.green = q_s5;
			end
			hsvd_pkg::SEC_B_TO_M: begin
				chan_mux.red   = t_s5;
				chan_mux.green = p_s5;
			end
			default: begin
				chan_mux.green = p_s5;
				chan_mux.blue  = q_s5;
			end
		endcase
	end

	// Valid bits travel with the data; the pipeline advances every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Payload registers of stages 2 to 6.
	always_ff @(posedge clk) begin
		sf_s2     <= 22'(pos_s1.sat) * 22'(pos_s1.frac);
		sg_s2     <= 22'(pos_s1.sat) * 22'(frac_c);
		pv_s2     <= 24'(pos_s1.val) * 24'(hsvd_pkg::FullScale - pos_s1.sat);
		val_s2    <= pos_s1.val;
		sector_s2 <= pos_s1.sector;

		nq_s3     <= hsvd_pkg::TermTop - sf_s2;
		nt_s3     <= hsvd_pkg::TermTop - sg_s2;
		p_s3      <= pv_s2[23:12];
		val_s3    <= val_s2;
		sector_s3 <= sector_s2;

		dq_s4     <= prod_q[hsvd_pkg::Recip659Sh +: hsvd_pkg::CompW];
		dt_s4     <= prod_t[hsvd_pkg::Recip659Sh +: hsvd_pkg::CompW];
		p_s4      <= p_s3;
		val_s4    <= val_s3;
		sector_s4 <= sector_s3;

		q_s5      <= vq[23:12];
		t_s5      <= vt[23:12];
		p_s5      <= p_s4;
		val_s5    <= val_s4;
		sector_s5 <= sector_s4;

		chan_s6   <= chan_mux;
		val_s6    <= val_s5;
	end

	// No channel level may exceed the brightness it was derived from.
	a_chan_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (chan_s6.red <= val_s6) && (chan_s6.green <= val_s6)
			&& (chan_s6.blue <= val_s6) && (chan_s6.white <= val_s6))
		else $error("channel level above brightness");

	// Every sector drives one color channel at full brightness.
	a_val_present: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (chan_s6.red == val_s6) || (chan_s6.green == val_s6)
			|| (chan_s6.blue == val_s6))
		else $error("no channel carries the brightness");

	// The white level equals one of the color channels in every sector.
	a_white_present: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (chan_s6.white == chan_s6.red) || (chan_s6.white == chan_s6.green)
			|| (chan_s6.white == chan_s6.blue))
		else $error("white level matches no color channel");

endmodule

// ===== design/hsvd_duty.sv =====
// Stages 7 and 8 of the converter for one channel: range mode and percentage scaling.
// Depends on hsvd_pkg; instantiated once per channel by the top level.
module hsvd_duty (
	input  logic                       clk,
	input  logic [hsvd_pkg::CompW-1:0] level_s6,
	input  logic                       wide,
	input  logic [hsvd_pkg::PctW-1:0]  pct,
	output logic [hsvd_pkg::DutyW-1:0] duty_s8
);

	localparam int unsigned ProdW = hsvd_pkg::DutyW + hsvd_pkg::PctW;

	logic [hsvd_pkg::DutyW-1:0] level_w;
	logic [ProdW-1:0]           x_s7;
	logic [2*ProdW-1:0]         prod;

	// Wide mode counts to four times the level.
	always_comb begin
		if (wide) begin
			level_w = {level_s6, 2'b00};
		end else begin
			level_w = {2'b00, level_s6};
		end
	end

	// Divide by one hundred through the scaled reciprocal.
	assign prod = (2*ProdW)'(x_s7) * (2*ProdW)'(hsvd_pkg::Recip100);

	// Percentage product, then the truncated quotient.
	always_ff @(posedge clk) begin
		x_s7    <= ProdW'(level_w) * ProdW'(pct);
		duty_s8 <= prod[hsvd_pkg::Recip100Sh +: hsvd_pkg::DutyW];
	end

endmodule

// ===== design/hsv_to_rgbw_duty_top.sv =====
// Top level of the HSV to RGBW duty converter: register file, pipeline and result strobe.
// Depends on hsvd_pkg, hsvd_sector, hsvd_terms and hsvd_duty.
//
//   Channel   Handshake             Payload
//   input     start, busy           pixel (hue, saturation, brightness)
//   result    done (one cycle)      result (red, green, blue, white duty)
//   config    cfg_valid, cfg_ready  cfg_index, cfg_data
//
// One transaction enters per clock; each result passes through the eight pipeline stages
// (sector split, products, dividends, divide by 659, scale by value, channel mapping,
// percentage product, divide by 100) before done strobes it.
// Reset clears every valid bit and loads the register defaults (wide mode, 100 percent).
// busy stays low and cfg_ready high: nothing in the pipeline ever stalls.
module hsv_to_rgbw_duty_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  hsvd_pkg::hsvd_in_t        pixel,
	output logic                      done,
	output hsvd_pkg::hsvd_out_t       result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hsvd_pkg::IdxW-1:0] cfg_index,
	input  logic [hsvd_pkg::PctW-1:0] cfg_data
);

	logic                      wide_q;
	logic [hsvd_pkg::PctW-1:0] duty_red_q;
	logic [hsvd_pkg::PctW-1:0] duty_green_q;
	logic [hsvd_pkg::PctW-1:0] duty_blue_q;
	logic [hsvd_pkg::PctW-1:0] duty_white_q;
	logic [hsvd_pkg::PctW-1:0] pct_capped;

	logic                 accept;
	logic                 valid_s1;
	hsvd_pkg::hsvd_pos_t  pos_s1;
	logic                 valid_s6;
	hsvd_pkg::hsvd_chan_t chan_s6;
	logic                 valid_s7;
	logic                 valid_s8;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Percentages above one hundred act as one hundred.
	assign pct_capped = (cfg_data > hsvd_pkg::DutyMax) ? hsvd_pkg::DutyMax : cfg_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q       <= 1'b1;
			duty_red_q   <= hsvd_pkg::DutyMax;
			duty_green_q <= hsvd_pkg::DutyMax;
			duty_blue_q  <= hsvd_pkg::DutyMax;
			duty_white_q <= hsvd_pkg::DutyMax;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsvd_pkg::REG_WIDE:       wide_q       <= cfg_data[0];
				hsvd_pkg::REG_DUTY_RED:   duty_red_q   <= pct_capped;
				hsvd_pkg::REG_DUTY_GREEN: duty_green_q <= pct_capped;
				hsvd_pkg::REG_DUTY_BLUE:  duty_blue_q  <= pct_capped;
				hsvd_pkg::REG_DUTY_WHITE: duty_white_q <= pct_capped;
				default: ;
			endcase
		end
	end

	// Sector split.
	hsvd_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (accept),
		.pixel    (pixel),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1)
	);

	// Term computation and channel mapping.
	hsvd_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1),
		.valid_s6 (valid_s6),
		.chan_s6  (chan_s6)
	);

	// Per-channel duty scaling.
	hsvd_duty u_duty_red (
		.clk      (clk),
		.level_s6 (chan_s6.red),
		.wide     (wide_q),
		.pct      (duty_red_q),
		.duty_s8  (result.red_duty)
	);

	hsvd_duty u_duty_green (
		.clk      (clk),
		.level_s6 (chan_s6.green),
		.wide     (wide_q),
		.pct      (duty_green_q),
		.duty_s8  (result.green_duty)
	);

	hsvd_duty u_duty_blue (
		.clk      (clk),
		.level_s6 (chan_s6.blue),
		.wide     (wide_q),
		.pct      (duty_blue_q),
		.duty_s8  (result.blue_duty)
	);

	hsvd_duty u_duty_white (
		.clk      (clk),
		.level_s6 (chan_s6.white),
		.wide     (wide_q),
		.pct      (duty_white_q),
		.duty_s8  (result.white_duty)
	);

	// Valid bits of the scaling stages; the last one is the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	assign done = valid_s8;

	// Each result answers a transaction accepted earlier and carried through every pipeline stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 8))
		else $error("result without a matching input transaction");

	// Duty counts never pass four times full scale.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.red_duty <= 14'd16380) && (result.green_duty <= 14'd16380)
			&& (result.blue_duty <= 14'd16380) && (result.white_duty <= 14'd16380))
		else $error("duty count out of range");

	// Stored percentages stay capped at one hundred.
	a_pct_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (duty_red_q <= hsvd_pkg::DutyMax)
			&& (duty_green_q <= hsvd_pkg::DutyMax) && (duty_blue_q <= hsvd_pkg::DutyMax)
			&& (duty_white_q <= hsvd_pkg::DutyMax))
		else $error("percentage register above one hundred");

endmodule

// ===== bench/hsv_to_rgbw_duty_top_test.sv =====
// Self-checking testbench for the HSV to RGBW duty converter top level.
// Depends on hsvd_pkg and hsv_to_rgbw_duty_top; predicts every result with its own model
// of the conversion and compares each strobed result against it.
`timescale 1ns / 100ps

module hsv_to_rgbw_duty_top_test;

	// Register index that decodes to nothing; writes to it must leave the settings alone.
	localparam logic [hsvd_pkg::IdxW-1:0] RegUnused = 3'd7;
	// Cycles allowed after the last result before the settings may change.
	localparam int unsigned SettleCycles = 12;
	localparam int unsigned RandomPerPhase = 255;
	localparam int unsigned PhaseCount = 6;

	logic                          clk;
	logic                          arst_n;
	logic                          start = 1'b0;
	logic                          busy;
	hsvd_pkg::hsvd_in_t            pixel = '0;
	logic                          done;
	hsvd_pkg::hsvd_out_t           result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [hsvd_pkg::IdxW-1:0]     cfg_index = '0;
	logic [hsvd_pkg::PctW-1:0]     cfg_data = '0;

	// Model copy of the register file.
	bit                            wide_mode = 1'b1;
	logic [hsvd_pkg::PctW-1:0]     pct_red = hsvd_pkg::DutyMax;
	logic [hsvd_pkg::PctW-1:0]     pct_green = hsvd_pkg::DutyMax;
	logic [hsvd_pkg::PctW-1:0]     pct_blue = hsvd_pkg::DutyMax;
	logic [hsvd_pkg::PctW-1:0]     pct_white = hsvd_pkg::DutyMax;

	hsvd_pkg::hsvd_in_t            pending_pixels[$];
	hsvd_pkg::hsvd_out_t           awaited_duties[$];
	bit                            offer_taken = 1'b0;
	bit                            hold_input = 1'b0;
	int unsigned                   send_idle_pct = 0;
	int unsigned                   reg_writes = 0;
	int unsigned                   pixels_accepted = 0;
	int unsigned                   results_checked = 0;
	int unsigned                   error_count = 0;

	hsv_to_rgbw_duty_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A run that hangs is a failure.
	initial begin
		#4000000;
		$display("hsv_to_rgbw_duty_top_test failed");
		$finish;
	end

	// Scales one channel level by the mode and its clamped percentage.
	function automatic logic [hsvd_pkg::DutyW-1:0] scaled_duty(int unsigned level,
	                                                           logic [hsvd_pkg::PctW-1:0] pct);
		int unsigned clamped;
		int unsigned counts;
		clamped = (pct > hsvd_pkg::DutyMax) ? hsvd_pkg::DutyMax : pct;
		counts = wide_mode ? level * 4 : level;
		return hsvd_pkg::DutyW'((counts * clamped) / hsvd_pkg::DutyMax);
	endfunction

	// Expected duty counts for one color under the current settings.
	function automatic hsvd_pkg::hsvd_out_t rgbw_from_hsv(hsvd_pkg::hsvd_in_t px);
		int unsigned hue, sat, val, frac, p, q, t, red, green, blue;
		hsvd_pkg::hsvd_sector_t sector;
		hsvd_pkg::hsvd_out_t duties;
		hue = px.hue % hsvd_pkg::HueFold;
		sat = px.saturation;
		val = px.brightness;
		sector = hsvd_pkg::hsvd_sector_t'(3'(hue / hsvd_pkg::SectorSize));
		frac = hue % hsvd_pkg::SectorSize;
		p = (val * (hsvd_pkg::FullScale - sat)) / 4096;
		q = (val * ((hsvd_pkg::TermTop - sat * frac) / hsvd_pkg::SectorDiv)) / 4096;
		t = (val * ((hsvd_pkg::TermTop - sat * (hsvd_pkg::SectorDiv - frac))
		     / hsvd_pkg::SectorDiv)) / 4096;
		red = val;
		green = val;
		blue = val;
		case (sector)
			hsvd_pkg::SEC_R_TO_Y: begin green = t; blue = p; end
			hsvd_pkg::SEC_Y_TO_G: begin red = q; blue = p; end
			hsvd_pkg::SEC_G_TO_C: begin red = p; blue = t; end
			hsvd_pkg::SEC_C_TO_B: begin red = p; green = q; end
			hsvd_pkg::SEC_B_TO_M: begin red = t; green = p; end
			default: begin green = p; blue = q; end
		endcase
		duties.red_duty = scaled_duty(red, pct_red);
		duties.green_duty = scaled_duty(green, pct_green);
		duties.blue_duty = scaled_duty(blue, pct_blue);
		duties.white_duty = scaled_duty(p, pct_white);
		return duties;
	endfunction

	task automatic check_field(string name, logic [hsvd_pkg::DutyW-1:0] want,
	                           logic [hsvd_pkg::DutyW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Monitor: checks strobed results, records accepted colors and register writes.
	always @(posedge clk) begin
		hsvd_pkg::hsvd_out_t want;
		offer_taken = 1'b0;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (awaited_duties.size() == 0) begin
					$error("result strobed with no conversion outstanding");
					error_count++;
				end else begin
					want = awaited_duties.pop_front();
					check_field("red_duty", want.red_duty, result.red_duty);
					check_field("green_duty", want.green_duty, result.green_duty);
					check_field("blue_duty", want.blue_duty, result.blue_duty);
					check_field("white_duty", want.white_duty, result.white_duty);
					results_checked++;
				end
			end
			if (start && busy === 1'b0) begin
				offer_taken = 1'b1;
				awaited_duties.push_back(rgbw_from_hsv(pixel));
				pixels_accepted++;
			end
			if (cfg_valid && cfg_ready === 1'b1) begin
				case (cfg_index)
					hsvd_pkg::REG_WIDE:       wide_mode = cfg_data[0];
					hsvd_pkg::REG_DUTY_RED:   pct_red = cfg_data;
					hsvd_pkg::REG_DUTY_GREEN: pct_green = cfg_data;
					hsvd_pkg::REG_DUTY_BLUE:  pct_blue = cfg_data;
					hsvd_pkg::REG_DUTY_WHITE: pct_white = cfg_data;
					default: ;
				endcase
				reg_writes++;
			end
		end
	end

	// Driver: offers the next queued color once the previous one has been taken.
	always @(negedge clk) begin
		if (!start || offer_taken) begin
			if (pending_pixels.size() != 0 && !hold_input &&
			    $urandom_range(99) >= send_idle_pct) begin
				pixel <= pending_pixels.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_pixel(int unsigned hue, int unsigned sat, int unsigned val);
		hsvd_pkg::hsvd_in_t px;
		px.hue = hsvd_pkg::CompW'(hue);
		px.saturation = hsvd_pkg::CompW'(sat);
		px.brightness = hsvd_pkg::CompW'(val);
		pending_pixels.push_back(px);
	endtask

	// Random component, weighted toward full scale, zero and values near both, the hue sector edges and hue folding.
	function automatic logic [hsvd_pkg::CompW-1:0] rand_comp(bit is_hue);
		case ($urandom_range(7))
			0: return '0;
			1: return hsvd_pkg::FullScale;
			2: return is_hue ? hsvd_pkg::CompW'(hsvd_pkg::HueFold + $urandom_range(135))
			                 : hsvd_pkg::CompW'($urandom_range(15));
			3: return is_hue ? hsvd_pkg::CompW'($urandom_range(5) * hsvd_pkg::SectorSize
			                                    + ($urandom_range(1) ? 659 : 0))
			                 : hsvd_pkg::CompW'(hsvd_pkg::FullScale - $urandom_range(15));
			default: return hsvd_pkg::CompW'($urandom_range(4095));
		endcase
	endfunction

	task automatic write_reg(logic [hsvd_pkg::IdxW-1:0] idx, logic [hsvd_pkg::PctW-1:0] data);
		int unsigned seen;
		seen = reg_writes;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		while (reg_writes == seen)
			@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Returns once no color is queued, offered or in flight, then waits out the settle period.
	task automatic wait_drained();
		while (pending_pixels.size() != 0 || start || awaited_duties.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// Register settings for each phase after the first, which runs on reset values.
	task automatic configure_phase(int unsigned phase);
		case (phase)
			1: begin
				write_reg(hsvd_pkg::REG_WIDE, 7'h7E);
				write_reg(hsvd_pkg::REG_DUTY_RED, 7'd100);
				write_reg(hsvd_pkg::REG_DUTY_GREEN, 7'd50);
				write_reg(hsvd_pkg::REG_DUTY_BLUE, 7'd1);
				write_reg(hsvd_pkg::REG_DUTY_WHITE, 7'd0);
				write_reg(RegUnused, 7'd3);
			end
			2: begin
				write_reg(hsvd_pkg::REG_WIDE, 7'h01);
				write_reg(hsvd_pkg::REG_DUTY_RED, 7'd127);
				write_reg(hsvd_pkg::REG_DUTY_GREEN, 7'd101);
				write_reg(hsvd_pkg::REG_DUTY_BLUE, 7'd99);
				write_reg(hsvd_pkg::REG_DUTY_WHITE, 7'd100);
			end
			3: begin
				write_reg(hsvd_pkg::REG_WIDE, 7'h40);
				write_reg(hsvd_pkg::REG_DUTY_RED, 7'd0);
				write_reg(hsvd_pkg::REG_DUTY_GREEN, 7'd0);
				write_reg(hsvd_pkg::REG_DUTY_BLUE, 7'd0);
				write_reg(hsvd_pkg::REG_DUTY_WHITE, 7'd0);
			end
			default: begin
				write_reg(hsvd_pkg::REG_WIDE, hsvd_pkg::PctW'($urandom));
				write_reg(hsvd_pkg::REG_DUTY_RED, hsvd_pkg::PctW'($urandom_range(127)));
				write_reg(hsvd_pkg::REG_DUTY_GREEN, hsvd_pkg::PctW'($urandom_range(127)));
				write_reg(hsvd_pkg::REG_DUTY_BLUE, hsvd_pkg::PctW'($urandom_range(127)));
				write_reg(hsvd_pkg::REG_DUTY_WHITE, hsvd_pkg::PctW'($urandom_range(127)));
			end
		endcase
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned hue_marks[12] = '{0, 659, 660, 1319, 1320, 1980, 2640, 3300, 3959,
		                               3960, 4095, 330};
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
			// Sender idles often, then more often, then never.
			send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 60 : 0;
			if (phase == 0) begin
				// Sector edges, hue folding and the extremes of each field.
				foreach (hue_marks[i])
					push_pixel(hue_marks[i], 4095, 4095);
				push_pixel(0, 0, 4095);
				push_pixel(0, 4095, 0);
				push_pixel(0, 0, 0);
				push_pixel(1650, 2048, 4095);
				push_pixel(2970, 1, 4095);
				push_pixel(4000, 2047, 2048);
				push_pixel(990, 4094, 1);
			end else begin
				configure_phase(phase);
			end
			for (int unsigned n = 0; n < RandomPerPhase; n++)
				push_pixel(rand_comp(1'b1), rand_comp(1'b0), rand_comp(1'b0));

			// Midway, hold the input until the pipeline has emptied.
			while (pending_pixels.size() > RandomPerPhase / 2)
				@(negedge clk);
			hold_input = 1'b1;
			while (start || awaited_duties.size() != 0)
				@(negedge clk);
			hold_input = 1'b0;
			wait_drained();
		end

		$display("Checked %0d of %0d accepted conversions across %0d register settings",
		         results_checked, pixels_accepted, PhaseCount);
		$display("(%0d register writes), with narrow and wide counters and percentages 0-127.",
		         reg_writes);
		if (error_count == 0) begin
			$display("hsv_to_rgbw_duty_top_test passed");
		end else begin
			$display("hsv_to_rgbw_duty_top_test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hsvd_pkg.sv
design/hsvd_sector.sv
design/hsvd_terms.sv
design/hsvd_duty.sv
design/hsv_to_rgbw_duty_top.sv
bench/hsv_to_rgbw_duty_top_test.sv
